FILE: design/assert_macros.svh
// assertion helpers for the varying register grid packer
// no dependencies; taken in by the top level only
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset only
`define VRGP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset only
`define VRGP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/vrgp_pkg.sv
// shared types, codes and constants of the varying register grid packer
// no dependencies; used by controller, datapath and top level
package vrgp_pkg;

    localparam int MAX_ROWS_DEFAULT = 32;

    localparam int LIMIT_W   = 7;
    localparam int ROWS_W    = 7;
    localparam int COLS_W    = 3;
    localparam int ROW_IDX_W = 6;
    localparam int COL_IDX_W = 2;
    localparam int USED_W    = 7;
    localparam int NUM_COLS  = 4;

    localparam logic [LIMIT_W-1:0]   ROW_LIMIT_RESET = 7'd32;
    localparam logic                 MODE_CLEAR      = 1'b1;
    localparam logic [COLS_W-1:0]    COLS_ONE        = 3'd1;
    localparam logic [COLS_W-1:0]    COLS_TWO        = 3'd2;
    localparam logic [COLS_W-1:0]    COLS_THREE      = 3'd3;
    localparam logic [COLS_W-1:0]    COLS_FOUR       = 3'd4;
    localparam logic [NUM_COLS-1:0]  HIGH_PAIR_MASK  = 4'b1100;
    localparam logic [COL_IDX_W-1:0] HIGH_PAIR_COL   = 2'd2;

    typedef enum logic [2:0]
    {
        KIND_CLEAR,
        KIND_BAD,
        KIND_WIN_ZERO,
        KIND_WIN,
        KIND_WIN2,
        KIND_COL
    } item_kind_t;

    typedef enum logic [2:0]
    {
        CMD_NOP,
        CMD_LOAD,
        CMD_INIT,
        CMD_INIT_UP,
        CMD_SCAN_WIN,
        CMD_SCAN_COL,
        CMD_MARK,
        CMD_COUNT
    } cmd_op_t;

    typedef struct packed
    {
        cmd_op_t op;
    } dp_cmd_t;

    typedef struct packed
    {
        item_kind_t kind;
        logic       hit;
        logic       last;
    } dp_status_t;

    typedef enum logic [3:0]
    {
        S_IDLE,
        S_DISPATCH,
        S_WIN_DOWN,
        S_UP_INIT,
        S_WIN_UP,
        S_COL_SCAN,
        S_MARK,
        S_COUNT_INIT,
        S_COUNT,
        S_DONE
    } ctrl_state_t;

    // columns covered by a window anchored at column 0
    function automatic logic [NUM_COLS-1:0] win_mask(input logic [COLS_W-1:0] cols);
        logic [NUM_COLS-1:0] m;
        m = '0;
        unique case (cols)
            COLS_TWO:   m = 4'b0011;
            COLS_THREE: m = 4'b0111;
            COLS_FOUR:  m = 4'b1111;
            default:    m = '0;
        endcase
        return m;
    endfunction

endpackage

FILE: design/vrgp_ctrl.sv
// sequencing state machine of the varying register grid packer
// depends on vrgp_pkg; drives vrgp_dp through command and status structs
module vrgp_ctrl
    import vrgp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       out_free,
    output logic       out_load,
    output dp_cmd_t    cmd,
    input  dp_status_t status
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = CMD_NOP;
        in_ready   = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = CMD_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                cmd.op = CMD_INIT;
                unique case (status.kind)
                    KIND_WIN, KIND_WIN2: state_next = S_WIN_DOWN;
                    KIND_COL:            state_next = S_COL_SCAN;
                    default:             state_next = S_COUNT;
                endcase
            end
            S_WIN_DOWN:
            begin
                cmd.op = CMD_SCAN_WIN;
                priority if (status.hit)
                begin
                    state_next = S_MARK;
                end
                else if (status.last)
                begin
                    state_next = (status.kind == KIND_WIN2) ? S_UP_INIT : S_COUNT_INIT;
                end
            end
            S_UP_INIT:
            begin
                cmd.op     = CMD_INIT_UP;
                state_next = S_WIN_UP;
            end
            S_WIN_UP:
            begin
                cmd.op = CMD_SCAN_WIN;
                priority if (status.hit)
                begin
                    state_next = S_MARK;
                end
                else if (status.last)
                begin
                    state_next = S_COUNT_INIT;
                end
            end
            S_COL_SCAN:
            begin
                cmd.op = CMD_SCAN_COL;
                if (status.last)
                begin
                    state_next = S_MARK;
                end
            end
            S_MARK:
            begin
                cmd.op     = CMD_MARK;
                state_next = S_COUNT;
            end
            S_COUNT_INIT:
            begin
                cmd.op     = CMD_INIT;
                state_next = S_COUNT;
            end
            S_COUNT:
            begin
                cmd.op = CMD_COUNT;
                if (status.last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: design/vrgp_dp.sv
// occupancy grid, row walker and placement registers of the grid packer
// depends on vrgp_pkg; commanded by vrgp_ctrl
module vrgp_dp
    import vrgp_pkg::*;
#(
    parameter int MAX_ROWS = MAX_ROWS_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  dp_cmd_t              cmd,
    output dp_status_t           status,
    input  logic                 in_mode,
    input  logic [ROWS_W-1:0]    in_rows,
    input  logic [COLS_W-1:0]    in_cols,
    input  logic [LIMIT_W-1:0]   row_limit,
    output logic                 res_placed,
    output logic [ROW_IDX_W-1:0] res_row,
    output logic [COL_IDX_W-1:0] res_col,
    output logic [USED_W-1:0]    res_used
);

    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW = $clog2(MAX_ROWS + 1);
    localparam int AW = 8;

    logic [NUM_COLS-1:0]  grid_reg [MAX_ROWS];
    logic [NUM_COLS-1:0]  grid_next [MAX_ROWS];
    logic [ROWS_W-1:0]    rows_reg, rows_next;
    logic [COLS_W-1:0]    cols_reg, cols_next;
    item_kind_t           kind_reg, kind_next;
    logic [RW-1:0]        ptr_reg, ptr_next;
    logic [CW-1:0]        run_reg, run_next;
    logic [RW-1:0]        win_start_reg, win_start_next;
    logic                 win_high_reg, win_high_next;
    logic [CW-1:0]        space_reg [NUM_COLS];
    logic [CW-1:0]        space_next [NUM_COLS];
    logic [RW-1:0]        first_reg [NUM_COLS];
    logic [RW-1:0]        first_next [NUM_COLS];
    logic [NUM_COLS-1:0]  found_reg, found_next;
    logic [CW-1:0]        used_reg, used_next;
    logic                 placed_reg, placed_next;
    logic [RW-1:0]        row_reg, row_next;
    logic [COL_IDX_W-1:0] col_reg, col_next;

    logic [CW-1:0]        lim;
    logic                 row_valid;
    logic [NUM_COLS-1:0]  row_rd;
    logic [NUM_COLS-1:0]  cur_mask;
    logic                 row_free;
    logic [CW-1:0]        run_inc;
    logic                 hit;
    logic                 last_down;
    logic [COL_IDX_W-1:0] best;
    logic                 best_ok;
    logic [AW-1:0]        mark_lo, mark_hi;
    logic [NUM_COLS-1:0]  mark_mask;
    item_kind_t           in_kind;

    // effective limit, clipped to the grid height
    assign lim       = (row_limit > LIMIT_W'(MAX_ROWS)) ? CW'(MAX_ROWS) : CW'(row_limit);
    assign row_valid = (lim != '0);
    assign row_rd    = grid_reg[ptr_reg];
    assign cur_mask  = win_high_reg ? HIGH_PAIR_MASK : win_mask(cols_reg);
    assign row_free  = ((row_rd & cur_mask) == '0);
    assign run_inc   = run_reg + CW'(1);
    assign hit       = row_valid && row_free && (ROWS_W'(run_inc) == rows_reg);
    assign last_down = ((CW+1)'(ptr_reg) + (CW+1)'(1)) >= (CW+1)'(lim);

    assign status.kind = kind_reg;
    assign status.hit  = hit;
    assign status.last = !row_valid || (win_high_reg ? (ptr_reg == '0) : last_down);

    always_comb
    begin
        priority if (in_mode == MODE_CLEAR)
            in_kind = KIND_CLEAR;
        else if (in_cols >= COLS_TWO && in_cols <= COLS_FOUR)
            in_kind = (in_rows == '0) ? KIND_WIN_ZERO :
                      (in_cols == COLS_TWO) ? KIND_WIN2 : KIND_WIN;
        else if (in_cols == COLS_ONE)
            in_kind = KIND_COL;
        else
            in_kind = KIND_BAD;
    end

    // tightest column with enough free cells, lowest index on ties
    always_comb
    begin
        best = '0;
        for (int x = 0; x < NUM_COLS; x++)
        begin
            if (ROWS_W'(space_reg[x]) >= rows_reg &&
                (ROWS_W'(space_reg[best]) < rows_reg || space_reg[x] < space_reg[best]))
            begin
                best = COL_IDX_W'(x);
            end
        end
    end

    assign best_ok = ROWS_W'(space_reg[best]) >= rows_reg;

    always_comb
    begin
        if (kind_reg == KIND_COL)
        begin
            mark_lo   = AW'(first_reg[best]);
            mark_mask = (best_ok && found_reg[best]) ? (NUM_COLS'(1) << best) : '0;
        end
        else
        begin
            mark_lo   = AW'(win_start_reg);
            mark_mask = cur_mask;
        end
        mark_hi = mark_lo + AW'(rows_reg);
    end

    always_comb
    begin
        grid_next      = grid_reg;
        rows_next      = rows_reg;
        cols_next      = cols_reg;
        kind_next      = kind_reg;
        ptr_next       = ptr_reg;
        run_next       = run_reg;
        win_start_next = win_start_reg;
        win_high_next  = win_high_reg;
        space_next     = space_reg;
        first_next     = first_reg;
        found_next     = found_reg;
        used_next      = used_reg;
        placed_next    = placed_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        unique case (cmd.op)
            CMD_LOAD:
            begin
                rows_next     = in_rows;
                cols_next     = in_cols;
                kind_next     = in_kind;
                ptr_next      = '0;
                run_next      = '0;
                win_high_next = 1'b0;
                found_next    = '0;
                used_next     = '0;
                placed_next   = (in_kind == KIND_CLEAR) || (in_kind == KIND_WIN_ZERO);
                row_next      = '0;
                col_next      = '0;
                for (int x = 0; x < NUM_COLS; x++)
                begin
                    space_next[x] = '0;
                end
                if (in_kind == KIND_CLEAR)
                begin
                    for (int i = 0; i < MAX_ROWS; i++)
                    begin
                        grid_next[i] = '0;
                    end
                end
            end
            CMD_INIT:
            begin
                ptr_next      = '0;
                run_next      = '0;
                win_high_next = 1'b0;
            end
            CMD_INIT_UP:
            begin
                ptr_next      = RW'(lim - CW'(1));
                run_next      = '0;
                win_high_next = 1'b1;
            end
            CMD_SCAN_WIN:
            begin
                if (row_valid)
                begin
                    run_next = row_free ? run_inc : '0;
                end
                if (hit)
                begin
                    win_start_next = win_high_reg ? ptr_reg :
                                     RW'(AW'(ptr_reg) + AW'(1) - AW'(rows_reg));
                end
                ptr_next = win_high_reg ? (ptr_reg - RW'(1)) : (ptr_reg + RW'(1));
            end
            CMD_SCAN_COL:
            begin
                for (int x = 0; x < NUM_COLS; x++)
                begin
                    if (row_valid && !row_rd[x])
                    begin
                        space_next[x] = space_reg[x] + CW'(1);
                        if (!found_reg[x])
                        begin
                            found_next[x] = 1'b1;
                            first_next[x] = ptr_reg;
                        end
                    end
                end
                ptr_next = ptr_reg + RW'(1);
            end
            CMD_MARK:
            begin
                for (int i = 0; i < MAX_ROWS; i++)
                begin
                    if (AW'(i) >= mark_lo && AW'(i) < mark_hi && AW'(i) < AW'(lim))
                    begin
                        grid_next[i] = grid_reg[i] | mark_mask;
                    end
                end
                if (kind_reg == KIND_COL)
                begin
                    placed_next = best_ok;
                    row_next    = (best_ok && found_reg[best]) ? first_reg[best] : '0;
                    col_next    = best_ok ? best : '0;
                end
                else
                begin
                    placed_next = 1'b1;
                    row_next    = win_start_reg;
                    col_next    = win_high_reg ? HIGH_PAIR_COL : '0;
                end
                ptr_next      = '0;
                run_next      = '0;
                win_high_next = 1'b0;
            end
            CMD_COUNT:
            begin
                if (row_valid && row_rd != '0)
                begin
                    used_next = used_reg + CW'(1);
                end
                ptr_next = ptr_reg + RW'(1);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_ROWS; i++)
            begin
                grid_reg[i] <= '0;
            end
            kind_reg     <= KIND_BAD;
            ptr_reg      <= '0;
            run_reg      <= '0;
            win_high_reg <= 1'b0;
            found_reg    <= '0;
            used_reg     <= '0;
            placed_reg   <= 1'b0;
        end
        else
        begin
            grid_reg     <= grid_next;
            kind_reg     <= kind_next;
            ptr_reg      <= ptr_next;
            run_reg      <= run_next;
            win_high_reg <= win_high_next;
            found_reg    <= found_next;
            used_reg     <= used_next;
            placed_reg   <= placed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rows_reg      <= rows_next;
        cols_reg      <= cols_next;
        win_start_reg <= win_start_next;
        space_reg     <= space_next;
        first_reg     <= first_next;
        row_reg       <= row_next;
        col_reg       <= col_next;
    end

    assign res_placed = placed_reg;
    assign res_row    = ROW_IDX_W'(row_reg);
    assign res_col    = col_reg;
    assign res_used   = USED_W'(used_reg);

endmodule

FILE: design/varying_register_grid_packer_top.sv
// top level of the varying register grid packer: stream ports, limit register,
// result register; depends on vrgp_pkg, vrgp_ctrl, vrgp_dp and assert_macros.svh

// Varying register grid packer. Keeps a grid of MAX_ROWS register rows by four
// columns and places one variable per input word. A word with tuser set clears
// the grid. A pack word of 2 to 4 columns takes the first free window, walking
// rows top-down from column 0; a 2-column variable that misses is then tried
// bottom-up in columns 2 and 3. A 1-column variable goes to the column with the
// fewest sufficient free cells, from its first free row, clipped at the limit.
// Each input word gives exactly one result word. Words are handled one at a
// time; the row walker reads one grid row per cycle. With L the effective
// limit min(row_limit, MAX_ROWS), every item ends with a walk over the rows
// up to L that counts the used rows; a one-column variable first walks those
// rows for free cells, a window search of 2 to 4 columns stops at its first
// fit, and a two-column variable that misses walks them again bottom-up. A
// finished result sits in the output register, and the next input word is taken
// while it waits. The user must write the row_limit register through the cfg
// channel only while the block is idle; the block itself does not enforce it.
`include "assert_macros.svh"

module varying_register_grid_packer_top
    import vrgp_pkg::*;
#(
    parameter int MAX_ROWS = MAX_ROWS_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    // input words
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [15:0]         s_axis_tdata,   // rows_needed[6:0], columns_needed[9:7]
    input  logic                s_axis_tuser,   // mode (1 = clear the grid)
    // result words
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [15:0]         m_axis_tdata,   // row_index[5:0], column_index[7:6],
                                                // used_rows[14:8]
    output logic                m_axis_tuser,   // placed
    // row limit write channel
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [LIMIT_W-1:0]  cfg_data
);

    dp_cmd_t              cmd;
    dp_status_t           status;
    logic                 out_free;
    logic                 out_load;
    logic                 res_placed;
    logic [ROW_IDX_W-1:0] res_row;
    logic [COL_IDX_W-1:0] res_col;
    logic [USED_W-1:0]    res_used;

    logic [LIMIT_W-1:0]   row_limit_reg;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_placed_reg;
    logic [ROW_IDX_W-1:0] out_row_reg;
    logic [COL_IDX_W-1:0] out_col_reg;
    logic [USED_W-1:0]    out_used_reg;

    // row limit register, always ready to take a word
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_limit_reg <= ROW_LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            row_limit_reg <= cfg_data;
        end
    end

    vrgp_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .out_free (out_free),
        .out_load (out_load),
        .cmd      (cmd),
        .status   (status)
    );

    vrgp_dp #(
        .MAX_ROWS (MAX_ROWS)
    ) u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .in_mode    (s_axis_tuser),
        .in_rows    (s_axis_tdata[6:0]),
        .in_cols    (s_axis_tdata[9:7]),
        .row_limit  (row_limit_reg),
        .res_placed (res_placed),
        .res_row    (res_row),
        .res_col    (res_col),
        .res_used   (res_used)
    );

    // result register: free when empty or being drained this cycle
    assign out_free = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_placed_reg <= res_placed;
            out_row_reg    <= res_row;
            out_col_reg    <= res_col;
            out_used_reg   <= res_used;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_placed_reg;
    assign m_axis_tdata  = {1'b0, out_used_reg, out_col_reg, out_row_reg};

    // the walker is not ready again in the cycle after it takes a word
    `VRGP_ASSERT_NXT(a_busy_after_accept, clk, rst_n, s_axis_tvalid && s_axis_tready,
                     !s_axis_tready, "input taken while busy")
    // a new result never overwrites one still waiting
    `VRGP_ASSERT_IMP(a_load_needs_room, clk, rst_n, out_load, out_free,
                     "result register overrun")
    // a failed placement reports row and column zero
    `VRGP_ASSERT_IMP(a_fail_zero_pos, clk, rst_n, m_axis_tvalid && !m_axis_tuser,
                     m_axis_tdata[7:0] == 8'd0, "failed placement with nonzero position")
    // used rows never exceed the grid height
    `VRGP_ASSERT_IMP(a_used_in_range, clk, rst_n, m_axis_tvalid,
                     m_axis_tdata[14:8] <= USED_W'(MAX_ROWS), "used row count above grid height")

endmodule
